// ===== hw/rtl/utf8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8dec_pkg
// Shared constants and types of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8dec_pkg;

  // Replacement unit for any four-byte (or longer) lead
  localparam logic [15:0] BOX_UNIT = 16'h25A1;

  // Saturation value of the per-message unit index
  localparam logic [15:0] IDX_MAX = 16'hFFFF;

  // Continuation bytes swallowed after a four-byte lead
  localparam logic [1:0] SWALLOW_CNT = 2'd3;

  // Result queue: deep enough to take two units while two are still waiting
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [15:0] unit_index;
    logic        run_last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_to_ucs2_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Streaming UTF-8 to UCS-2 decoder, one byte in, up to two units out.
// ----------------------------------------------------------------------------
// Flow: an accepted byte waits in the input stage until the result queue
//   has room for two units; then its units are queued for out_valid.
// Throughput: one byte per cycle while the queue has room; a four-byte lead
//   yields two units that leave one at a time, so the queue sets the rate.
// Reset: synchronous, active low; clears sequence state, unit count, the
//   swap flag and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_swap_bytes,
  // byte input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_message_end,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_code_unit,
  output logic [15:0]      out_unit_index,
  output logic             out_run_last
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_TWO     = 3'd1,
    MODE_THREE_A = 3'd2,
    MODE_THREE_B = 3'd3,
    MODE_SWALLOW = 3'd4
  } mode_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic        swap_r;

  // input stage: the accepted byte waits here for one decode pass
  logic        stg_vld_r, stg_vld_nxt;
  logic [7:0]  stg_byte_r;
  logic        stg_end_r;

  // decoder state
  mode_t       mode_r, mode_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic [1:0]  swallow_r, swallow_nxt;
  logic [15:0] units_r, units_nxt;

  // result queue
  utf8dec_pkg::result_t             q_mem_r [utf8dec_pkg::QDEPTH];
  logic [utf8dec_pkg::QPTR_W-1:0]   q_wr_r, q_wr_nxt;
  logic [utf8dec_pkg::QPTR_W-1:0]   q_rd_r, q_rd_nxt;
  logic [utf8dec_pkg::QCNT_W-1:0]   q_cnt_r, q_cnt_nxt;

  localparam logic [utf8dec_pkg::QCNT_W-1:0] QROOM_LIM =
    utf8dec_pkg::QCNT_W'(utf8dec_pkg::QDEPTH - 2);

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic fire;     // staged byte is decoded this cycle
  logic in_acc;
  logic out_acc;

  // Decode only when the queue can take a pair of units.
  assign fire      = stg_vld_r && (q_cnt_r <= QROOM_LIM);
  assign in_ready  = !stg_vld_r || fire;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = (q_cnt_r != '0);
  assign out_acc   = out_valid && out_ready;

  // --------------------------------------------------------------------------
  // Decode of the staged byte
  // --------------------------------------------------------------------------
  logic        is_cont;
  logic        handled;
  logic [1:0]  n_units;
  logic [15:0] unit0, unit1;
  logic [15:0] idx1, idx2;
  logic [15:0] unit0_sw, unit1_sw;

  // next index, saturating
  assign idx1 = (units_r == utf8dec_pkg::IDX_MAX) ? units_r : units_r + 16'd1;
  assign idx2 = (idx1 == utf8dec_pkg::IDX_MAX) ? idx1 : idx1 + 16'd1;

  assign is_cont = stg_byte_r[7];

  always_comb begin
    mode_nxt    = mode_r;
    partial_nxt = partial_r;
    swallow_nxt = swallow_r;
    units_nxt   = units_r;
    handled     = 1'b0;
    n_units     = 2'd0;
    unit0       = utf8dec_pkg::BOX_UNIT;
    unit1       = utf8dec_pkg::BOX_UNIT;

    if (fire) begin
      // bytes with the top bit set feeding an open sequence
      if (is_cont) begin
        case (mode_r)
          MODE_TWO, MODE_THREE_B: begin
            unit0    = partial_r | {10'd0, stg_byte_r[5:0]};
            n_units  = 2'd1;
            mode_nxt = MODE_IDLE;
            handled  = 1'b1;
          end
          MODE_THREE_A: begin
            partial_nxt = partial_r | {4'd0, stg_byte_r[5:0], 6'd0};
            mode_nxt    = MODE_THREE_B;
            handled     = 1'b1;
          end
          MODE_SWALLOW: begin
            swallow_nxt = swallow_r - 2'd1;
            if (swallow_nxt == 2'd0) begin
              mode_nxt = MODE_IDLE;
            end
            handled = 1'b1;
          end
          default: begin
            handled = 1'b0;   // idle and unused codes
          end
        endcase
      end

      // fresh byte: anything a sequence did not consume
      if (!handled) begin
        mode_nxt    = MODE_IDLE;
        swallow_nxt = 2'd0;
        if (!is_cont) begin
          unit0   = {9'd0, stg_byte_r[6:0]};
          n_units = 2'd1;
        end else if (stg_byte_r[7:4] == 4'hF) begin
          n_units     = 2'd2;
          mode_nxt    = MODE_SWALLOW;
          swallow_nxt = utf8dec_pkg::SWALLOW_CNT;
        end else if (stg_byte_r[7:4] == 4'hE) begin
          partial_nxt = {stg_byte_r[3:0], 12'd0};
          mode_nxt    = MODE_THREE_A;
        end else if (stg_byte_r[7:5] == 3'b110) begin
          partial_nxt = {5'd0, stg_byte_r[4:0], 6'd0};
          mode_nxt    = MODE_TWO;
        end
        // stray continuation byte: dropped
      end

      case (n_units)
        2'd1:    units_nxt = idx1;
        2'd2:    units_nxt = idx2;
        default: units_nxt = units_r;
      endcase

      // end of message clears everything that is message scoped
      if (stg_end_r) begin
        mode_nxt    = MODE_IDLE;
        partial_nxt = 16'd0;
        swallow_nxt = 2'd0;
        units_nxt   = 16'd0;
      end
    end
  end

  assign unit0_sw = swap_r ? {unit0[7:0], unit0[15:8]} : unit0;
  assign unit1_sw = swap_r ? {unit1[7:0], unit1[15:8]} : unit1;

  // --------------------------------------------------------------------------
  // Queue pointers and input stage
  // --------------------------------------------------------------------------
  always_comb begin
    q_wr_nxt  = q_wr_r + utf8dec_pkg::QPTR_W'(n_units);
    q_rd_nxt  = out_acc ? q_rd_r + 1'b1 : q_rd_r;
    q_cnt_nxt = q_cnt_r + utf8dec_pkg::QCNT_W'(n_units)
              - utf8dec_pkg::QCNT_W'(out_acc);
    stg_vld_nxt = in_acc ? 1'b1 : (fire ? 1'b0 : stg_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r    <= 1'b0;
      stg_vld_r <= 1'b0;
      mode_r    <= MODE_IDLE;
      partial_r <= 16'd0;
      swallow_r <= 2'd0;
      units_r   <= 16'd0;
      q_wr_r    <= '0;
      q_rd_r    <= '0;
      q_cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        swap_r <= cfg_swap_bytes;
      end
      stg_vld_r <= stg_vld_nxt;
      mode_r    <= mode_nxt;
      partial_r <= partial_nxt;
      swallow_r <= swallow_nxt;
      units_r   <= units_nxt;
      q_wr_r    <= q_wr_nxt;
      q_rd_r    <= q_rd_nxt;
      q_cnt_r   <= q_cnt_nxt;
    end
  end

  // payload: staged byte and queue storage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_text_byte;
      stg_end_r  <= in_message_end;
    end
    if (n_units != 2'd0) begin
      q_mem_r[q_wr_r] <= '{code_unit:  unit0_sw,
                           unit_index: units_r,
                           run_last:   (n_units == 2'd1)};
    end
    if (n_units == 2'd2) begin
      q_mem_r[q_wr_r + 1'b1] <= '{code_unit:  unit1_sw,
                                  unit_index: idx1,
                                  run_last:   1'b1};
    end
  end

  assign out_code_unit  = q_mem_r[q_rd_r].code_unit;
  assign out_unit_index = q_mem_r[q_rd_r].unit_index;
  assign out_run_last   = q_mem_r[q_rd_r].run_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= utf8dec_pkg::QCNT_W'(utf8dec_pkg::QDEPTH))
    else $error("result queue overflow");

  // a pair of replacement units leaves at least two entries queued
  a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (n_units == 2'd2) |=> (q_cnt_r >= utf8dec_pkg::QCNT_W'(2)))
    else $error("replacement pair not queued");

  // decode only happens on a staged byte
  a_fire_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (n_units != 2'd0) |-> stg_vld_r)
    else $error("units produced without a staged byte");

  // empty stage always takes a new transaction
  a_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_vld_r |-> in_ready)
    else $error("input stalled with empty stage");
`endif

endmodule

`default_nettype wire

// ===== test/utf8_to_ucs2_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_tb
// Self-checking bench for the UTF-8 to UCS-2 decoder. Bytes go in over a
// valid/ready channel, and every decoded unit is compared field by field
// against an in-bench decoder that tracks the same sequence state. Directed
// corner cases come first, then output hold-off and randomised messages
// under several idling mixes and both byte orders.
// ----------------------------------------------------------------------------

module utf8_to_ucs2_decoder_tb;

  localparam int HOLD_LEN      = 300;   // cycles of forced output stall
  localparam int SETTLE_CYCLES = 4;     // decode latency plus margin
  localparam int DRAIN_LIMIT   = 5000;  // cycles allowed for outstanding units
  localparam int REPORT_MAX    = 10;

  // Sequence state of the in-bench decoder
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_TWO,
    SEQ_THREE_A,
    SEQ_THREE_B,
    SEQ_SWALLOW
  } seq_mode_t;

  // DUT connections, all inputs known from time zero
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic        cfg_swap_bytes = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte   = 8'h00;
  logic        in_message_end = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [15:0] out_code_unit;
  logic [15:0] out_unit_index;
  logic        out_run_last;

  // Decoder shadow state
  seq_mode_t   dec_mode    = SEQ_IDLE;
  logic [15:0] dec_partial = '0;
  logic [1:0]  dec_swallow = '0;
  logic [15:0] dec_count   = '0;
  logic        dec_swap    = 1'b0;

  utf8dec_pkg::result_t expected_units[$];
  logic [7:0]           message_bytes[$];

  // Handshake flags, refreshed at every rising edge
  logic in_acc  = 1'b0;
  logic cfg_acc = 1'b0;

  // Idling controls
  int   gap_pct   = 0;   // sender, used by the stimulus process only
  int   stall_pct = 0;   // receiver, always updated non-blocking
  logic hold_go   = 1'b0;
  int   hold_left = 0;

  int fault_count    = 0;
  int units_checked  = 0;
  int bytes_accepted = 0;

  utf8_to_ucs2_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_swap_bytes (cfg_swap_bytes),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_unit_index (out_unit_index),
    .out_run_last   (out_run_last)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // In-bench decoder
  // --------------------------------------------------------------------------

  // Builds one unit with its index; the index count saturates
  function automatic utf8dec_pkg::result_t make_unit(input logic [15:0] u);
    utf8dec_pkg::result_t r;
    r.code_unit  = dec_swap ? {u[7:0], u[15:8]} : u;
    r.unit_index = dec_count;
    r.run_last   = 1'b0;
    if (dec_count != utf8dec_pkg::IDX_MAX) dec_count++;
    return r;
  endfunction

  // Works out the units caused by one accepted byte and queues them
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    utf8dec_pkg::result_t units[2];
    int      n;
    logic    taken;
    n     = 0;
    taken = 1'b0;
    // Any byte with the top bit set may continue an open sequence
    if (b[7]) begin
      case (dec_mode)
        SEQ_TWO: begin
          units[n] = make_unit(dec_partial | {10'b0, b[5:0]});
          n++;
          dec_mode = SEQ_IDLE;
          taken    = 1'b1;
        end
        SEQ_THREE_A: begin
          dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
          dec_mode    = SEQ_THREE_B;
          taken       = 1'b1;
        end
        SEQ_THREE_B: begin
          units[n] = make_unit(dec_partial | {10'b0, b[5:0]});
          n++;
          dec_mode = SEQ_IDLE;
          taken    = 1'b1;
        end
        SEQ_SWALLOW: begin
          dec_swallow = dec_swallow - 2'd1;
          if (dec_swallow == 2'd0) dec_mode = SEQ_IDLE;
          taken = 1'b1;
        end
        default: ;
      endcase
    end
    // Fresh byte: a partial unit or swallow run is dropped here
    if (!taken) begin
      dec_mode    = SEQ_IDLE;
      dec_swallow = '0;
      if (!b[7]) begin
        units[n] = make_unit({9'b0, b[6:0]});
        n++;
      end else if (b >= 8'hF0) begin
        units[n] = make_unit(utf8dec_pkg::BOX_UNIT);
        n++;
        units[n] = make_unit(utf8dec_pkg::BOX_UNIT);
        n++;
        dec_mode    = SEQ_SWALLOW;
        dec_swallow = utf8dec_pkg::SWALLOW_CNT;
      end else if (b >= 8'hE0) begin
        dec_partial = {b[3:0], 12'b0};
        dec_mode    = SEQ_THREE_A;
      end else if (b >= 8'hC0) begin
        dec_partial = {5'b0, b[4:0], 6'b0};
        dec_mode    = SEQ_TWO;
      end
      // a stray continuation byte falls through and is dropped
    end
    if (n > 0) units[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_units = {expected_units, units[i]};
    // End of message clears everything but the swap flag
    if (last) begin
      dec_mode    = SEQ_IDLE;
      dec_partial = '0;
      dec_swallow = '0;
      dec_count   = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_unit();
    utf8dec_pkg::result_t want;
    units_checked++;
    if (expected_units.size() == 0) begin
      note_fault($sformatf("unit %h index %0d arrived with nothing outstanding",
                           out_code_unit, out_unit_index));
    end else begin
      want = expected_units.pop_front();
      if (out_code_unit !== want.code_unit || out_unit_index !== want.unit_index ||
          out_run_last !== want.run_last) begin
        note_fault($sformatf("unit/index/last expected %h/%0d/%0b, got %h/%0d/%0b",
                             want.code_unit, want.unit_index, want.run_last,
                             out_code_unit, out_unit_index, out_run_last));
      end
    end
  endfunction

  // All sampling happens here at the rising edge; outputs are checked before
  // the byte accepted on the same edge is predicted, since its units come later
  always @(posedge clk) begin
    in_acc  = rst_n && in_valid && in_ready;
    cfg_acc = rst_n && cfg_valid && cfg_ready;
    if (rst_n && out_valid && out_ready) check_unit();
    if (in_acc) begin
      bytes_accepted++;
      predict_byte(in_text_byte, in_message_end);
    end
    if (cfg_acc) dec_swap = cfg_swap_bytes;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_LEN;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // --------------------------------------------------------------------------

  // One byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_message_end <= last;
    do @(negedge clk); while (!in_acc);
  endtask

  // Stops sending and waits for every outstanding unit, then lets the
  // pipeline settle in case the last bytes produced nothing
  task automatic wait_drain();
    int guard;
    in_valid <= 1'b0;
    @(negedge clk);
    for (guard = 0; guard < DRAIN_LIMIT && expected_units.size() != 0; guard++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Swap flag write; only called with the decoder idle
  task automatic write_swap(input logic swap);
    cfg_valid      <= 1'b1;
    cfg_swap_bytes <= swap;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    // mostly proper continuations, sometimes a lead byte in that position
    if ($urandom_range(3) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Appends one byte to the message being built
  function automatic void add_byte(input logic [7:0] b);
    message_bytes = {message_bytes, b};
  endfunction

  // Fills message_bytes with a short message, mostly well-formed characters
  task automatic build_message();
    int target;
    int kind;
    int k;
    message_bytes.delete();
    target = $urandom_range(1, 24);
    while (message_bytes.size() < target) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        add_byte(8'($urandom_range(0, 8'h7F)));
      end else if (kind < 50) begin
        add_byte(8'($urandom_range(8'hC0, 8'hDF)));
        add_byte(cont_byte());
      end else if (kind < 70) begin
        add_byte(8'($urandom_range(8'hE0, 8'hEF)));
        add_byte(cont_byte());
        add_byte(cont_byte());
      end else if (kind < 78) begin
        // four-byte lead, with a short, full or overlong tail
        add_byte(8'($urandom_range(8'hF0, 8'hFF)));
        k = $urandom_range(0, 4);
        repeat (k) add_byte(cont_byte());
      end else if (kind < 86) begin
        // lead byte, maybe one continuation, then a plain ASCII byte
        add_byte(8'($urandom_range(8'hC0, 8'hEF)));
        if ($urandom_range(1)) add_byte(cont_byte());
        add_byte(8'($urandom_range(0, 8'h7F)));
      end else begin
        add_byte(8'($urandom));
      end
    end
    // now and then the message ends on an open lead
    if ($urandom_range(9) == 0) add_byte(8'($urandom_range(8'hC0, 8'hEF)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and each special case, default byte order
  task automatic test_directed_cases();
    gap_pct = 0;
    stall_pct <= 0;
    send_byte(8'h00, 1'b0);               // ASCII extremes
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC0, 1'b0);               // smallest two-byte
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);               // largest two-byte
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0);               // smallest three-byte
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);               // largest three-byte, unit FFFF
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);               // box pair, three swallowed ...
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);               // ... and the fourth is a stray
    send_byte(8'hFF, 1'b0);               // swallowing cut short by ASCII
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);               // two-byte lead broken by ASCII
    send_byte(8'h41, 1'b0);
    send_byte(8'hBF, 1'b0);               // stray continuation, dropped
    send_byte(8'hE2, 1'b0);               // three-byte cut off by end of message
    send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);               // new message starts at index 0
    wait_drain();
  endtask

  // Output held off while bytes keep coming, so the input must stall
  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct <= 0;
    @(posedge clk);
    hold_go = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_byte(8'hF5, i == 39);
      else send_byte(8'($urandom_range(8'h20, 8'h7E)), i == 39);
    end
    wait_drain();
  endtask

  // Random messages under one idling mix and one byte order
  task automatic test_random_text(input int gap, input int stall, input logic swap,
                                  input int n_bytes);
    int sent;
    sent = 0;
    write_swap(swap);
    gap_pct = gap;
    stall_pct <= stall;
    while (sent < n_bytes) begin
      build_message();
      foreach (message_bytes[i])
        send_byte(message_bytes[i], i == message_bytes.size() - 1);
      sent += message_bytes.size();
    end
    wait_drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_backpressure();
    test_random_text(0,  0,  1'b1, 320);   // no idling, big-endian
    test_random_text(62, 0,  1'b0, 320);   // sparse input
    test_random_text(0,  62, 1'b1, 320);   // stalling output
    test_random_text(7,  7,  1'b0, 320);   // light idling on both sides

    if (expected_units.size() != 0)
      note_fault($sformatf("%0d units never arrived", expected_units.size()));

    $display("Run covered %0d bytes and %0d units: corner cases, a %0d-cycle hold-off,",
             bytes_accepted, units_checked, HOLD_LEN);
    $display("and random messages under four idling mixes in both byte orders.");
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Run stopped by watchdog, %0d units outstanding", expected_units.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
